// ----- sv/tdp_pkg.sv -----
`timescale 1ns / 1ps

package tdp_pkg;

    // Default width of the tested value
    localparam int VALUE_BITS_DEFAULT = 31;

    // Smallest prime; values below it are not prime
    localparam int SMALLEST_PRIME = 2;

    // First odd trial divisor
    localparam int FIRST_ODD_DIVISOR = 3;

    // Status returned by the shared remainder unit
    typedef struct packed {
        logic done;      // one-cycle pulse when the remainder is final
        logic rem_zero;  // remainder is zero (valid with done)
    } tdp_div_status_t;

endpackage

// ----- sv/tdp_value_if.sv -----
`timescale 1ns / 1ps

interface tdp_value_if #(
    parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- sv/tdp_result_if.sv -----
`timescale 1ns / 1ps

interface tdp_result_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

// ----- sv/tdp_divider.sv -----
`timescale 1ns / 1ps

// Radix-2 restoring remainder unit: one dividend bit per cycle.
module tdp_divider #(
    parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEFAULT,
    parameter int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [VALUE_BITS-1:0]         dividend,
    input  logic [DIV_BITS-1:0]           divisor,
    output tdp_pkg::tdp_div_status_t      status
);
    import tdp_pkg::*;

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [VALUE_BITS-1:0] dividend_reg;
    logic [DIV_BITS-1:0]   divisor_reg;
    logic [DIV_BITS-1:0]   rem_reg;
    logic [DIV_BITS-1:0]   rem_next;
    logic [DIV_BITS:0]     trial;

    // Shift the next dividend bit in and subtract when it fits
    always_comb
    begin
        trial = {rem_reg, dividend_reg[VALUE_BITS-1]};
        if (trial >= {1'b0, divisor_reg})
        begin
            rem_next = DIV_BITS'(trial - {1'b0, divisor_reg});
        end
        else
        begin
            rem_next = trial[DIV_BITS-1:0];
        end
    end

    // Control: count down one bit a cycle, pulse done at the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_BITS'(VALUE_BITS);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
                if (count_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: operands and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= dividend;
            divisor_reg  <= divisor;
            rem_reg      <= '0;
        end
        else if (busy_reg)
        begin
            dividend_reg <= {dividend_reg[VALUE_BITS-2:0], 1'b0};
            rem_reg      <= rem_next;
        end
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

// ----- sv/trial_division_prime_test_core.sv -----
`timescale 1ns / 1ps

// Channel   Interface       Dir  Payload
// request   tdp_value_if    in   value    [VALUE_BITS-1:0], unsigned
// result    tdp_result_if   out  is_prime [0:0]
//
// One item at a time. Values below four and even values are settled
// without a division, and so are odd values below nine. Other odd
// values try every odd divisor d with d*d <= value, each on the shared
// radix-2 remainder unit.
// Reset clears the sequencer and the output valid flag; no clearing pass.
// A stalled result is held in the output register; the next item is taken
// meanwhile and waits for the slot before its result is loaded.
module trial_division_prime_test_core #(
    parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEFAULT
) (
    input logic         clk,
    input logic         rst_n,
    tdp_value_if.sink   request,
    tdp_result_if.source result
);
    import tdp_pkg::*;

    localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS  = VALUE_BITS + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_RESULT
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [DIV_BITS-1:0]   d_reg, d_next;
    logic [SQ_BITS-1:0]    sq_reg, sq_next;
    logic                  pend_reg, pend_next;
    logic                  start_reg, start_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_prime_reg, out_prime_next;
    tdp_div_status_t       div_status;

    tdp_divider #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_BITS   (DIV_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (value_reg),
        .divisor  (d_reg),
        .status   (div_status)
    );

    // Sequencer: screen small and even values, then step odd divisors
    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        pend_next      = pend_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;

        // Drop the result once taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    value_next = request.value;
                    d_next     = DIV_BITS'(FIRST_ODD_DIVISOR);
                    sq_next    = SQ_BITS'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR);
                    if (request.value < VALUE_BITS'(SMALLEST_PRIME))
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_RESULT;
                    end
                    else if (request.value < VALUE_BITS'(2 * SMALLEST_PRIME))
                    begin
                        pend_next  = 1'b1;
                        state_next = ST_RESULT;
                    end
                    else if (!request.value[0])
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                // Stop once d*d exceeds the value
                if (sq_reg > {1'b0, value_reg})
                begin
                    pend_next  = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    start_next = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    if (div_status.rem_zero)
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        // Advance to d+2: (d+2)^2 = d^2 + 4d + 4
                        d_next     = d_reg + DIV_BITS'(2);
                        sq_next    = sq_reg + SQ_BITS'({d_reg, 2'b00}) + SQ_BITS'(4);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_RESULT:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        pend_reg      <= pend_next;
        out_prime_reg <= out_prime_next;
    end

    assign request.ready   = (state_reg == ST_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.is_prime = out_prime_reg;

endmodule

// ----- sv/tdp_checker.sv -----
`timescale 1ns / 1ps

module tdp_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_is_prime
);

    // One item at a time: no new item right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("request ready stayed high after an item was taken");

    // A fresh result is loaded as the sequencer goes back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
    else $error("result appeared while an item was still being worked");

    // Returning to idle always leaves a result on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
    else $error("sequencer went idle without producing a result");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_is_prime)))
    else $error("stalled result changed or was dropped");

endmodule

bind trial_division_prime_test_core tdp_checker u_tdp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (request.valid),
    .in_ready     (request.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_is_prime (result.is_prime)
);
